FILE: design/sjs_pkg.sv
package sjs_pkg;

	localparam int MAX_PROCESSES_DEF = 64;
	localparam int TIME_W = 48;
	localparam int RATE_W = 32;
	localparam int PIDX_W = 6;
	localparam int NL_W = 38;               // -ln(u), Q6.32
	localparam int NUM_W = NL_W + 16;       // dividend, Q.48
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam logic [0:0] MODE_LOAD = 1'b0;
	localparam logic [0:0] MODE_DRAW = 1'b1;
	localparam logic [0:0] REG_MAX_STEP = 1'b0;
	localparam logic [0:0] REG_STOP_TIME = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_SQ_MUL,
		ST_SQ_UPD,
		ST_LN_FRAC,
		ST_LN_INT,
		ST_LN_ADD,
		ST_DIV,
		ST_CHECK,
		ST_PICK_LO,
		ST_PICK_HI,
		ST_PICK_SUM,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_FIN
	} state_t;

endpackage

FILE: design/sjs_ram.sv
module sjs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/stochastic_jump_step.sv
// One jump step of the direct method, in fixed point.
// Input channel (in_valid/in_ready): mode 0 words append one process rate to the
// store and its running sum while the store is not full; they give no result.
// Mode 1 words draw a step: wait = -ln((wait_random+1)/2^32)/total_rate, clamped
// to max_step, then a roulette pick over the stored rates if the step is not
// clamped, now_time plus the step stays within stop_time, pick_random is nonzero
// and the running sum is nonzero. Output channel (out_valid/out_ready): one word
// per draw, held in a register. A draw runs on one shared 32x32 multiplier and a
// bit-serial divider; a zero total_rate goes straight to the result, else the
// steps are normalize, squaring, log, divide, check, pick setup, rate walk.
// in_ready is low while a draw is in flight. A finished result waits in the last
// state while the previous word is still not taken; the store is not touched then.
// Config writes (cfg_we) are taken any cycle; write them only while idle.
// Reset clears the rate count, the running sum, max_step and stop_time; stored
// rates are not cleared, only entries below the count are ever read.
module stochastic_jump_step #(
	parameter int MAX_PROCESSES = sjs_pkg::MAX_PROCESSES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [sjs_pkg::TIME_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic [sjs_pkg::RATE_W-1:0] rate_value,
	input  logic [sjs_pkg::TIME_W-1:0] now_time,
	input  logic [sjs_pkg::RATE_W-1:0] total_rate,
	input  logic [31:0]                wait_random,
	input  logic [31:0]                pick_random,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sjs_pkg::TIME_W-1:0] step_time,
	output logic                       process_found,
	output logic [sjs_pkg::PIDX_W-1:0] process_index
);

	localparam int AW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CW = $clog2(MAX_PROCESSES + 1);
	localparam int SUM_W = 32 + $clog2(MAX_PROCESSES);
	localparam int TW = sjs_pkg::TIME_W;
	localparam int NW = sjs_pkg::NUM_W;

	sjs_pkg::state_t state_q, state_d;

	logic [TW-1:0]    max_step_q, stop_time_q;
	logic [CW-1:0]    count_q;
	logic [SUM_W-1:0] sum_q;

	logic [TW-1:0]    now_q;
	logic [31:0]      rate_q, pick_q;
	logic [31:0]      m_q, frac_q;
	logic [5:0]       e_q;
	logic [4:0]       k_q;
	logic [63:0]      prod_q;
	logic [32:0]      nlf_q;
	logic [NW-1:0]    num_q;
	logic [31:0]      rem_q;
	logic [5:0]       cnt_q;
	logic [31:0]      lo_q, hpart_q;
	logic [SUM_W:0]   hi_q;
	logic [SUM_W-1:0] cum_q;
	logic [AW-1:0]    idx_q;
	logic             found_q;
	logic [TW-1:0]    res_step_q;
	logic [sjs_pkg::PIDX_W-1:0] pidx_q;

	logic             out_valid_q;
	logic [TW-1:0]    out_step_q;
	logic             out_found_q;
	logic [sjs_pkg::PIDX_W-1:0] out_idx_q;

	logic [31:0] mul_a, mul_b;
	logic [31:0] rd_data;

	logic acc, load_en, draw_en, fin_go;
	logic [32:0] x_w, sq_t, div_rem_w;
	logic [37:0] lg_w;
	logic [64:0] nlf_w;
	logic        div_ge, over_w, past_w, pick_ok, hit_w, last_w;
	logic [TW:0] end_w;
	logic [SUM_W-1:0] cum_w;

	assign in_ready = (state_q == sjs_pkg::ST_IDLE);
	assign acc      = in_valid & in_ready;
	assign load_en  = acc & (mode == sjs_pkg::MODE_LOAD);
	assign draw_en  = acc & (mode == sjs_pkg::MODE_DRAW);
	assign fin_go   = (state_q == sjs_pkg::ST_FIN) & (~out_valid_q | out_ready);

	assign x_w       = {1'b0, wait_random} + 33'd1;
	assign sq_t      = prod_q[63:31];
	assign lg_w      = {6'd32, 32'd0} - {e_q, frac_q};
	assign nlf_w     = {1'b0, prod_q} + 65'h80000000;
	assign div_rem_w = {rem_q, num_q[NW-1]};
	assign div_ge    = div_rem_w >= {1'b0, rate_q};
	assign over_w    = num_q > NW'(max_step_q);
	assign end_w     = {1'b0, now_q} + {1'b0, num_q[TW-1:0]};
	assign past_w    = end_w > {1'b0, stop_time_q};
	assign pick_ok   = (pick_q != 32'd0) && (sum_q != '0);
	assign cum_w     = cum_q + SUM_W'(rd_data);
	assign hit_w     = ({1'b0, cum_w} > hi_q) || ({1'b0, cum_w} == hi_q && lo_q == 32'd0);
	assign last_w    = (CW'(idx_q) + CW'(1)) == count_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			sjs_pkg::ST_SQ_MUL: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			sjs_pkg::ST_LN_FRAC: begin
				mul_a = lg_w[31:0];
				mul_b = sjs_pkg::LN2_Q32;
			end
			sjs_pkg::ST_LN_INT: begin
				mul_a = 32'(lg_w[37:32]);
				mul_b = sjs_pkg::LN2_Q32;
			end
			sjs_pkg::ST_PICK_LO: begin
				mul_a = pick_q;
				mul_b = sum_q[31:0];
			end
			sjs_pkg::ST_PICK_HI: begin
				mul_a = pick_q;
				mul_b = 32'(sum_q >> 32);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	sjs_ram #(
		.WIDTH(32),
		.DEPTH(MAX_PROCESSES)
	) u_ram (
		.clk  (clk),
		.we   (load_en && (count_q < CW'(MAX_PROCESSES))),
		.waddr(count_q[AW-1:0]),
		.wdata(rate_value),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sjs_pkg::ST_IDLE: begin
				if (draw_en) begin
					if (total_rate == 32'd0) begin
						state_d = sjs_pkg::ST_FIN;
					end else if (x_w[32]) begin
						state_d = sjs_pkg::ST_SQ_MUL;
					end else begin
						state_d = sjs_pkg::ST_NORM;
					end
				end
			end
			sjs_pkg::ST_NORM: begin
				if (m_q[31]) begin
					state_d = sjs_pkg::ST_SQ_MUL;
				end
			end
			sjs_pkg::ST_SQ_MUL: state_d = sjs_pkg::ST_SQ_UPD;
			sjs_pkg::ST_SQ_UPD: begin
				state_d = (k_q == 5'd31) ? sjs_pkg::ST_LN_FRAC : sjs_pkg::ST_SQ_MUL;
			end
			sjs_pkg::ST_LN_FRAC: state_d = sjs_pkg::ST_LN_INT;
			sjs_pkg::ST_LN_INT: state_d = sjs_pkg::ST_LN_ADD;
			sjs_pkg::ST_LN_ADD: state_d = sjs_pkg::ST_DIV;
			sjs_pkg::ST_DIV: begin
				if (cnt_q == 6'(NW - 1)) begin
					state_d = sjs_pkg::ST_CHECK;
				end
			end
			sjs_pkg::ST_CHECK: begin
				if (!over_w && !past_w && pick_ok) begin
					state_d = sjs_pkg::ST_PICK_LO;
				end else begin
					state_d = sjs_pkg::ST_FIN;
				end
			end
			sjs_pkg::ST_PICK_LO: state_d = sjs_pkg::ST_PICK_HI;
			sjs_pkg::ST_PICK_HI: state_d = sjs_pkg::ST_PICK_SUM;
			sjs_pkg::ST_PICK_SUM: state_d = sjs_pkg::ST_WALK_RD;
			sjs_pkg::ST_WALK_RD: state_d = sjs_pkg::ST_WALK_CMP;
			sjs_pkg::ST_WALK_CMP: begin
				state_d = (hit_w || last_w) ? sjs_pkg::ST_FIN : sjs_pkg::ST_WALK_RD;
			end
			sjs_pkg::ST_FIN: begin
				if (fin_go) begin
					state_d = sjs_pkg::ST_IDLE;
				end
			end
			default: state_d = sjs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sjs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			sum_q       <= '0;
			max_step_q  <= '0;
			stop_time_q <= '0;
		end else begin
			state_q <= state_d;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_en && (count_q < CW'(MAX_PROCESSES))) begin
				count_q <= count_q + CW'(1);
				sum_q   <= sum_q + SUM_W'(rate_value);
			end
			if (cfg_we) begin
				if (cfg_index == sjs_pkg::REG_MAX_STEP) begin
					max_step_q <= cfg_data;
				end
				if (cfg_index == sjs_pkg::REG_STOP_TIME) begin
					stop_time_q <= cfg_data;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			sjs_pkg::ST_IDLE: begin
				now_q   <= now_time;
				rate_q  <= total_rate;
				pick_q  <= pick_random;
				found_q <= 1'b0;
				pidx_q  <= '0;
				k_q     <= '0;
				frac_q  <= '0;
				res_step_q <= max_step_q;
				if (x_w[32]) begin
					m_q <= 32'h80000000;
					e_q <= 6'd32;
				end else begin
					m_q <= x_w[31:0];
					e_q <= 6'd31;
				end
			end
			sjs_pkg::ST_NORM: begin
				if (!m_q[31]) begin
					m_q <= {m_q[30:0], 1'b0};
					e_q <= e_q - 6'd1;
				end
			end
			sjs_pkg::ST_SQ_UPD: begin
				frac_q <= {frac_q[30:0], sq_t[32]};
				m_q    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
				k_q    <= k_q + 5'd1;
			end
			sjs_pkg::ST_LN_INT: begin
				nlf_q <= nlf_w[64:32];
			end
			sjs_pkg::ST_LN_ADD: begin
				num_q <= {prod_q[37:0] + 38'(nlf_q), 16'd0};
				rem_q <= '0;
				cnt_q <= '0;
			end
			sjs_pkg::ST_DIV: begin
				rem_q <= div_ge ? 32'(div_rem_w - {1'b0, rate_q}) : div_rem_w[31:0];
				num_q <= {num_q[NW-2:0], div_ge};
				cnt_q <= cnt_q + 6'd1;
			end
			sjs_pkg::ST_CHECK: begin
				res_step_q <= over_w ? max_step_q : num_q[TW-1:0];
			end
			sjs_pkg::ST_PICK_HI: begin
				lo_q    <= prod_q[31:0];
				hpart_q <= prod_q[63:32];
			end
			sjs_pkg::ST_PICK_SUM: begin
				hi_q  <= (SUM_W+1)'(prod_q) + (SUM_W+1)'(hpart_q);
				cum_q <= '0;
				idx_q <= '0;
			end
			sjs_pkg::ST_WALK_CMP: begin
				cum_q <= cum_w;
				if (hit_w) begin
					found_q <= 1'b1;
					pidx_q  <= sjs_pkg::PIDX_W'(idx_q);
				end else if (!last_w) begin
					idx_q <= idx_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
		if (fin_go) begin
			out_step_q  <= res_step_q;
			out_found_q <= found_q;
			out_idx_q   <= found_q ? pidx_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign step_time     = out_step_q;
	assign process_found = out_found_q;
	assign process_index = out_idx_q;

endmodule

FILE: design/sjs_chk.sv
module sjs_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       mode,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [sjs_pkg::TIME_W-1:0] step_time,
	input logic                       process_found,
	input logic [sjs_pkg::PIDX_W-1:0] process_index
);

	// a draw word always makes the block busy in the cycle after it is taken
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == sjs_pkg::MODE_DRAW |=> !in_ready)
		else $error("input ready right after a draw");

	// a rate load finishes in the cycle it is taken
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == sjs_pkg::MODE_LOAD |=> in_ready)
		else $error("input not ready after a rate load");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !process_found |-> process_index == '0)
		else $error("index nonzero with no process");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(step_time) && $stable(process_found)
			&& $stable(process_index))
		else $error("output word changed while stalled");

endmodule

bind stochastic_jump_step sjs_chk u_sjs_chk (.*);
